// ===== sv/wmlv_pkg.sv =====
// shared types and constants of the window mode label vote block
// no dependencies
package wmlv_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_LABEL_BITS = 8;

    // coordinate width covers the largest image size allowed (1023 from the 10 bit size registers)
    localparam int CRD_W  = 13;
    // signed width for window bound arithmetic
    localparam int SGN_W  = 15;
    localparam int CNT_W  = 16;
    localparam int CIDX_W = 2;
    localparam int QDEPTH = 2;

    typedef enum logic [CIDX_W-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_WINDOW_WIDTH  = 2'd2,
        REG_WINDOW_HEIGHT = 2'd3
    } t_reg_idx;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // classified command passed from front to back
    typedef struct packed {
        logic             cmd;
        logic             empty;
        logic [CRD_W-1:0] x0;
        logic [CRD_W-1:0] x1;
        logic [CRD_W-1:0] y0;
        logic [CRD_W-1:0] y1;
        logic [8:0]       px;
        logic [8:0]       py;
        logic [7:0]       lab;
    } t_desc;

endpackage

// ===== sv/wmlv_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// no dependencies
module wmlv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/wmlv_front.sv =====
// front end: config registers, window clipping and a short command queue
// depends on wmlv_pkg
module wmlv_front import wmlv_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [9:0]        i_cfg_data,
    input  logic              push,
    output logic              full,
    input  logic              i_command,
    input  logic [8:0]        i_pixel_x,
    input  logic [8:0]        i_pixel_y,
    input  logic [7:0]        i_pixel_label,
    input  logic signed [12:0] i_query_u,
    input  logic signed [12:0] i_query_v,
    output logic              o_q_valid,
    output t_desc             o_q_desc,
    input  logic              i_q_pop
);
    logic [9:0] r_img_w, r_img_h;
    logic [7:0] r_win_w, r_win_h;

    // configuration writes
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= 10'd512;
            r_img_h <= 10'd512;
            r_win_w <= 8'd16;
            r_win_h <= 8'd16;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_IMAGE_WIDTH:   r_img_w <= i_cfg_data;
                REG_IMAGE_HEIGHT:  r_img_h <= i_cfg_data;
                REG_WINDOW_WIDTH:  r_win_w <= i_cfg_data[7:0];
                REG_WINDOW_HEIGHT: r_win_h <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // window bounds, clipped to the image in use
    logic [CRD_W:0] lim_w, lim_h, iw, ih;
    logic signed [SGN_W-1:0] ax, bx, ay, by, lox, hix, loy, hiy;
    logic empty_win;
    t_desc desc;

    always_comb begin
        iw = (CRD_W+1)'(r_img_w);
        ih = (CRD_W+1)'(r_img_h);
        lim_w = (iw > (CRD_W+1)'(MAX_WIDTH)) ? (CRD_W+1)'(MAX_WIDTH) : iw;
        lim_h = (ih > (CRD_W+1)'(MAX_HEIGHT)) ? (CRD_W+1)'(MAX_HEIGHT) : ih;
        ax = SGN_W'(i_query_u) - SGN_W'(signed'({1'b0, r_win_w[7:1]}));
        bx = SGN_W'(i_query_u) + SGN_W'(signed'({1'b0, r_win_w[7:1]}));
        ay = SGN_W'(i_query_v) - SGN_W'(signed'({1'b0, r_win_h[7:1]}));
        by = SGN_W'(i_query_v) + SGN_W'(signed'({1'b0, r_win_h[7:1]}));
        lox = (ax < 0) ? '0 : ax;
        loy = (ay < 0) ? '0 : ay;
        hix = (bx > signed'(SGN_W'(lim_w))) ? signed'(SGN_W'(lim_w)) : bx;
        hiy = (by > signed'(SGN_W'(lim_h))) ? signed'(SGN_W'(lim_h)) : by;
        empty_win = (lim_w == '0) || (lim_h == '0) || (lox >= hix) || (loy >= hiy);
        desc.cmd   = i_command;
        desc.empty = empty_win;
        desc.x0    = CRD_W'(lox);
        desc.x1    = CRD_W'(hix);
        desc.y0    = CRD_W'(loy);
        desc.y1    = CRD_W'(hiy);
        desc.px    = i_pixel_x;
        desc.py    = i_pixel_y;
        desc.lab   = i_pixel_label;
    end

    // two entry command queue
    t_desc r_q [QDEPTH];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic do_push, do_pop;

    assign full      = (r_cnt == 2'(QDEPTH));
    assign do_push   = push && !full;
    assign do_pop    = i_q_pop && (r_cnt != '0);
    assign o_q_valid = (r_cnt != '0);
    assign o_q_desc  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule

// ===== sv/wmlv_back.sv =====
// back end: image store, histogram accumulation, mode search and result register
// depends on wmlv_pkg and wmlv_ram
module wmlv_back import wmlv_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int LABEL_BITS = DEF_LABEL_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_desc       i_q_desc,
    output logic        o_q_pop,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_mode_label,
    output logic [15:0] o_vote_count,
    output logic        o_found
);
    localparam int NBINS = 1 << LABEL_BITS;
    localparam int IDEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int IAW = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_MAX   = 6'b010000,
        ST_HOLD  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [CRD_W-1:0] r_c, r_r, r_x0, r_x1, r_y1;
    logic [LABEL_BITS:0] r_b;
    logic r_s1, r_s2, r_m;
    logic [LABEL_BITS-1:0] r_s2_lab, r_m_bin, r_w_lab, r_best;
    logic r_w_valid;
    logic [CNT_W-1:0] r_w_cnt, r_best_cnt;
    logic r_res_valid, r_res_found;
    logic [LABEL_BITS-1:0] r_res_lab;
    logic [CNT_W-1:0] r_res_cnt;

    // image store
    logic i_we;
    logic [IAW-1:0] i_waddr, i_raddr;
    logic [LABEL_BITS-1:0] i_rdata;
    logic take, wr_ok, last_col, last_row;

    assign take = (r_state == ST_IDLE) && i_q_valid;
    assign o_q_pop = take;
    assign wr_ok = (CRD_W'(i_q_desc.px) < CRD_W'(MAX_WIDTH)) &&
                   (CRD_W'(i_q_desc.py) < CRD_W'(MAX_HEIGHT));
    assign i_we = take && (i_q_desc.cmd == CMD_WRITE) && wr_ok;
    assign i_waddr = IAW'(i_q_desc.py) * IAW'(MAX_WIDTH) + IAW'(i_q_desc.px);
    assign i_raddr = IAW'(r_r) * IAW'(MAX_WIDTH) + IAW'(r_c);

    wmlv_ram #(.WIDTH(LABEL_BITS), .DEPTH(IDEPTH)) u_img (
        .i_clk  (i_clk),
        .i_we   (i_we),
        .i_waddr(i_waddr),
        .i_wdata(i_q_desc.lab[LABEL_BITS-1:0]),
        .i_raddr(i_raddr),
        .o_rdata(i_rdata)
    );

    // histogram store with a one deep bypass on the increment
    logic h_we;
    logic [LABEL_BITS-1:0] h_waddr, h_raddr;
    logic [CNT_W-1:0] h_wdata, h_rdata, inc_cnt;

    assign inc_cnt = ((r_w_valid && (r_w_lab == r_s2_lab)) ? r_w_cnt : h_rdata) + 1'b1;

    always_comb begin
        h_we    = 1'b0;
        h_waddr = r_b[LABEL_BITS-1:0];
        h_wdata = '0;
        h_raddr = r_s1 ? i_rdata : r_b[LABEL_BITS-1:0];
        if (r_state == ST_CLEAR) begin
            h_we = 1'b1;
        end else if (r_s2) begin
            h_we    = 1'b1;
            h_waddr = r_s2_lab;
            h_wdata = inc_cnt;
        end else if (r_m) begin
            h_we    = 1'b1;
            h_waddr = r_m_bin;
        end
    end

    wmlv_ram #(.WIDTH(CNT_W), .DEPTH(NBINS)) u_hist (
        .i_clk  (i_clk),
        .i_we   (h_we),
        .i_waddr(h_waddr),
        .i_wdata(h_wdata),
        .i_raddr(h_raddr),
        .o_rdata(h_rdata)
    );

    // sequencer
    assign last_col = (r_c + 1'b1) == r_x1;
    assign last_row = (r_r + 1'b1) == r_y1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_b == (LABEL_BITS+1)'(NBINS - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (take && (i_q_desc.cmd == CMD_QUERY)) begin
                    n_state = i_q_desc.empty ? ST_HOLD : ST_SCAN;
                end
            end
            ST_SCAN:  if (last_col && last_row) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_s1 && !r_s2) n_state = ST_MAX;
            ST_MAX:   if (r_m && (r_m_bin == LABEL_BITS'(NBINS - 1))) n_state = ST_HOLD;
            ST_HOLD:  if (!r_res_valid) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_b         <= '0;
            r_s1        <= 1'b0;
            r_s2        <= 1'b0;
            r_m         <= 1'b0;
            r_w_valid   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_s1      <= (r_state == ST_SCAN);
            r_s2      <= r_s1;
            r_w_valid <= r_s2;
            r_m       <= (r_state == ST_MAX) && !r_b[LABEL_BITS];
            if (r_state == ST_CLEAR || r_state == ST_MAX) begin
                r_b <= r_b + 1'b1;
            end else begin
                r_b <= '0;
            end
            if (r_state == ST_HOLD && !r_res_valid) begin
                r_res_valid <= 1'b1;
            end else if (pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // window walk, pipeline payload and running maximum
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_c  <= i_q_desc.x0;
            r_r  <= i_q_desc.y0;
            r_x0 <= i_q_desc.x0;
            r_x1 <= i_q_desc.x1;
            r_y1 <= i_q_desc.y1;
            r_best     <= '0;
            r_best_cnt <= '0;
        end else if (r_state == ST_SCAN) begin
            if (last_col) begin
                r_c <= r_x0;
                r_r <= r_r + 1'b1;
            end else begin
                r_c <= r_c + 1'b1;
            end
        end
        r_s2_lab <= i_rdata;
        r_w_lab  <= r_s2_lab;
        r_w_cnt  <= inc_cnt;
        r_m_bin  <= r_b[LABEL_BITS-1:0];
        if (r_m && ((r_m_bin == '0) || (h_rdata > r_best_cnt))) begin
            r_best     <= r_m_bin;
            r_best_cnt <= h_rdata;
        end
        if (r_state == ST_HOLD && !r_res_valid) begin
            r_res_lab   <= r_best;
            r_res_cnt   <= r_best_cnt;
            r_res_found <= (r_best_cnt != '0);
        end
    end

    assign empty        = !r_res_valid;
    assign o_mode_label = 8'(r_res_lab);
    assign o_vote_count = r_res_cnt;
    assign o_found      = r_res_found;

    // a waiting result is held until it is taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !pop |=> r_res_valid)
        else $error("result dropped before transfer");
    // increments only come from a window walk
    a_s2_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2 |-> (r_state == ST_SCAN) || (r_state == ST_DRAIN))
        else $error("histogram increment outside window walk");
    // mode search never overlaps pending increments
    a_max_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAX) |-> !r_s1 && !r_s2)
        else $error("mode search overlaps accumulation");
    // nothing is taken from the queue outside idle
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == ST_IDLE))
        else $error("queue transfer outside idle");
endmodule

// ===== sv/window_mode_label_vote.sv =====
// top level of the window mode label vote block
// depends on wmlv_pkg, wmlv_front, wmlv_back (and wmlv_ram below it)
//
//  channel   direction  transfer when              payload
//  input     in         push && !full              command, pixel_x/y/label, query_u/v
//  result    out        pop && !empty              mode_label, vote_count, found
//  config    in         i_cfg_valid && o_cfg_ready i_cfg_index, i_cfg_data
//
// a pixel write is taken from the queue in the idle state; a query walks its
// window one pixel per cycle through the image ram and histogram increment,
// then searches the histogram one bin per cycle, and a query with an empty
// window goes straight to the result step.
// after reset the back end first clears every histogram bin;
// the command queue still takes up to two items meanwhile.
// full rises when the two entry queue is full; a result not popped stalls
// the back end in its final step.
module window_mode_label_vote import wmlv_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int LABEL_BITS = DEF_LABEL_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [9:0]         i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic               i_command,
    input  logic [8:0]         i_pixel_x,
    input  logic [8:0]         i_pixel_y,
    input  logic [7:0]         i_pixel_label,
    input  logic signed [12:0] i_query_u,
    input  logic signed [12:0] i_query_v,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_mode_label,
    output logic [15:0]        o_vote_count,
    output logic               o_found
);
    logic  q_valid, q_pop;
    t_desc q_desc;

    // classify and queue
    wmlv_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .full         (full),
        .i_command    (i_command),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_pixel_label(i_pixel_label),
        .i_query_u    (i_query_u),
        .i_query_v    (i_query_v),
        .o_q_valid    (q_valid),
        .o_q_desc     (q_desc),
        .i_q_pop      (q_pop)
    );

    // execute
    wmlv_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .LABEL_BITS(LABEL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_desc    (q_desc),
        .o_q_pop     (q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_mode_label(o_mode_label),
        .o_vote_count(o_vote_count),
        .o_found     (o_found)
    );
endmodule

// ===== bench/window_mode_label_vote_tb.sv =====
// self-checking bench for the window mode label vote block
// depends on wmlv_pkg and the window_mode_label_vote rtl; needs nothing else
module window_mode_label_vote_tb import wmlv_pkg::*;;

    localparam int IMG_SIDE  = 512;
    localparam int HOLD_CYC  = 400;
    localparam int SETTLE    = 300;

    // predicts mode votes from a mirrored label image and tracks pending ones
    class vote_board;
        typedef struct {
            logic [7:0]  lab;
            logic [15:0] cnt;
            logic        fnd;
        } t_vote;

        logic [7:0]  img   [0:IMG_SIDE*IMG_SIDE-1];
        bit          seen  [0:IMG_SIDE*IMG_SIDE-1];
        int          img_w, img_h, win_w, win_h;
        t_vote       pending_votes[$];
        int          errors;

        function new();
            img_w  = 512;
            img_h  = 512;
            win_w  = 16;
            win_h  = 16;
            errors = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [9:0] d);
            case (idx)
                REG_IMAGE_WIDTH:   img_w = d;
                REG_IMAGE_HEIGHT:  img_h = d;
                REG_WINDOW_WIDTH:  win_w = d[7:0];
                REG_WINDOW_HEIGHT: win_h = d[7:0];
                default: ;
            endcase
        endfunction

        // clipped half-open window bounds along one axis
        function void clip_axis(int c, int win, int lim, output int lo, output int hi);
            lo = c - win / 2;
            hi = c + win / 2;
            if (lo < 0) lo = 0;
            if (hi > lim) hi = lim;
        endfunction

        function void window_of(int u, int v, output int u0, output int u1,
                                output int v0, output int v1, output bit none);
            int w;
            int h;
            w = (img_w > IMG_SIDE) ? IMG_SIDE : img_w;
            h = (img_h > IMG_SIDE) ? IMG_SIDE : img_h;
            clip_axis(u, win_w, w, u0, u1);
            clip_axis(v, win_h, h, v0, v1);
            none = (w == 0) || (h == 0) || (u0 >= u1) || (v0 >= v1);
        endfunction

        // true when a query here only reads pixels that were written
        function bit covered(int u, int v);
            int u0, u1, v0, v1;
            bit none;
            window_of(u, v, u0, u1, v0, v1, none);
            if (none) return 1;
            for (int r = v0; r < v1; r++)
                for (int c = u0; c < u1; c++)
                    if (!seen[r*IMG_SIDE + c]) return 0;
            return 1;
        endfunction

        function t_vote vote_of_window(int u, int v);
            int u0, u1, v0, v1;
            bit none;
            int hist [256];
            t_vote res;
            res = '{lab: 8'd0, cnt: 16'd0, fnd: 1'b0};
            window_of(u, v, u0, u1, v0, v1, none);
            if (none) return res;
            foreach (hist[b]) hist[b] = 0;
            for (int r = v0; r < v1; r++)
                for (int c = u0; c < u1; c++)
                    hist[img[r*IMG_SIDE + c]]++;
            res.fnd = 1'b1;
            res.cnt = hist[0];
            for (int b = 1; b < 256; b++)
                if (hist[b] > res.cnt) begin
                    res.cnt = hist[b];
                    res.lab = b;
                end
            return res;
        endfunction

        // called for every accepted input transfer
        function void note_item(logic cmd, logic [8:0] x, logic [8:0] y, logic [7:0] lab,
                                logic signed [12:0] u, logic signed [12:0] v);
            if (cmd == CMD_WRITE) begin
                img[y*IMG_SIDE + x]  = lab;
                seen[y*IMG_SIDE + x] = 1;
            end else begin
                pending_votes.push_back(vote_of_window(int'(u), int'(v)));
            end
        endfunction

        // called for every accepted result transfer
        function void check_result(logic [7:0] lab, logic [15:0] cnt, logic fnd);
            t_vote exp_v;
            if (pending_votes.size() == 0) begin
                $display("%0t unexpected result: label %0d count %0d found %0b",
                         $time, lab, cnt, fnd);
                errors++;
                return;
            end
            exp_v = pending_votes.pop_front();
            if (lab !== exp_v.lab) begin
                $display("%0t mode_label expected %0d actual %0d", $time, exp_v.lab, lab);
                errors++;
            end
            if (cnt !== exp_v.cnt) begin
                $display("%0t vote_count expected %0d actual %0d", $time, exp_v.cnt, cnt);
                errors++;
            end
            if (fnd !== exp_v.fnd) begin
                $display("%0t found expected %0b actual %0b", $time, exp_v.fnd, fnd);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CIDX_W-1:0]  i_cfg_index;
    logic [9:0]         i_cfg_data;
    logic               push;
    logic               full;
    logic               i_command;
    logic [8:0]         i_pixel_x;
    logic [8:0]         i_pixel_y;
    logic [7:0]         i_pixel_label;
    logic signed [12:0] i_query_u;
    logic signed [12:0] i_query_v;
    logic               empty;
    logic               pop;
    logic [7:0]         o_mode_label;
    logic [15:0]        o_vote_count;
    logic               o_found;

    vote_board sb;
    bit        calm;
    bit        hold_req;

    window_mode_label_vote u_top (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

    // one input transfer; push stays high for a following item
    task automatic send_item(logic cmd, logic [8:0] x, logic [8:0] y, logic [7:0] lab,
                             logic signed [12:0] u, logic signed [12:0] v);
        while (!calm && $urandom_range(0, 99) < 20) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_command     <= cmd;
        i_pixel_x     <= x;
        i_pixel_y     <= y;
        i_pixel_label <= lab;
        i_query_u     <= u;
        i_query_v     <= v;
        do @(posedge i_clk); while (full);
        sb.note_item(cmd, x, y, lab, u, v);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [9:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering, wait for every vote, then let trailing writes settle
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_votes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_config(logic [9:0] w, logic [9:0] h, logic [9:0] ww, logic [9:0] wh);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_WINDOW_WIDTH, ww);
        write_reg(REG_WINDOW_HEIGHT, wh);
    endtask

    // query only where the window reads written pixels, else far outside
    task automatic send_query(logic signed [12:0] u, logic signed [12:0] v);
        if (!sb.covered(int'(u), int'(v))) begin
            u = -13'sd4096;
            v = -13'sd4096;
        end
        send_item(CMD_QUERY, $urandom, $urandom, $urandom, u, v);
    endtask

    // random mix: writes near the dense corner or anywhere, queries mostly near it
    task automatic random_items(int n);
        logic signed [12:0] u, v;
        logic [7:0] lab;
        for (int k = 0; k < n; k++) begin
            lab = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 40) begin
                if ($urandom_range(0, 1))
                    send_item(CMD_WRITE, $urandom_range(0, 31), $urandom_range(0, 31), lab,
                              $urandom, $urandom);
                else
                    send_item(CMD_WRITE, $urandom, $urandom, lab, $urandom, $urandom);
            end else begin
                for (int t = 0; t < 8; t++) begin
                    if ($urandom_range(0, 2) == 0) begin
                        u = $urandom;
                        v = $urandom;
                    end else begin
                        u = $urandom_range(0, 60) - 20;
                        v = $urandom_range(0, 60) - 20;
                    end
                    if (sb.covered(int'(u), int'(v))) break;
                end
                send_query(u, v);
            end
        end
    endtask

    // result side: random pop with an optional long hold-off
    initial begin
        pop <= 1'b0;
        @(posedge i_clk);
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYC) @(posedge i_clk);
                hold_req = 0;
            end else begin
                pop <= calm || ($urandom_range(0, 99) >= 20);
                @(posedge i_clk);
                if (pop && !empty) sb.check_result(o_mode_label, o_vote_count, o_found);
            end
        end
    end

    // stimulus
    initial begin
        sb            = new();
        calm          = 0;
        hold_req      = 0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_IMAGE_WIDTH;
        i_cfg_data    = '0;
        push          = 1'b0;
        i_command     = CMD_WRITE;
        i_pixel_x     = '0;
        i_pixel_y     = '0;
        i_pixel_label = '0;
        i_query_u     = '0;
        i_query_v     = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: fill the dense corner, then extremes
        for (int r = 0; r < 16; r++)
            for (int c = 0; c < 16; c++)
                send_item(CMD_WRITE, c, r, $urandom_range(0, 3), $urandom, $urandom);
        send_item(CMD_WRITE, 9'd511, 9'd511, 8'd255, 13'sd0, 13'sd0);
        send_item(CMD_WRITE, 9'd511, 9'd0, 8'd0, -13'sd1, -13'sd1);
        send_item(CMD_WRITE, 9'd0, 9'd511, 8'd128, 13'sd4095, -13'sd4096);
        send_query(13'sd8, 13'sd8);
        send_query(13'sd0, 13'sd0);
        send_query(-13'sd4096, -13'sd4096);
        send_query(13'sd4095, 13'sd4095);
        send_query(13'sd520, 13'sd520);
        // equal counts: two labels on a fully written 2x2 patch
        send_item(CMD_WRITE, 9'd3, 9'd3, 8'd7, 13'sd0, 13'sd0);
        send_item(CMD_WRITE, 9'd4, 9'd3, 8'd9, 13'sd0, 13'sd0);
        send_item(CMD_WRITE, 9'd3, 9'd4, 8'd9, 13'sd0, 13'sd0);
        send_item(CMD_WRITE, 9'd4, 9'd4, 8'd7, 13'sd0, 13'sd0);
        drain();
        set_config(10'd512, 10'd512, 10'd2, 10'd2);
        send_query(13'sd4, 13'sd4);
        send_query(13'sd511, 13'sd511);
        send_query(13'sd512, 13'sd512);
        random_items(55);
        drain();

        // whole window clipped to a small image, signed points everywhere
        set_config(10'd16, 10'd16, 10'd255, 10'd255);
        random_items(65);
        drain();

        // oversized image registers saturate
        set_config(10'd1023, 10'd1023, 10'd3, 10'd5);
        random_items(55);
        drain();

        // invalid image either way
        set_config(10'd0, 10'd20, 10'd8, 10'd8);
        random_items(40);
        drain();
        set_config(10'd20, 10'd0, 10'd8, 10'd8);
        random_items(40);
        drain();

        // zero and one wide windows are always empty
        set_config(10'd24, 10'd24, 10'd0, 10'd1);
        random_items(40);
        drain();

        // no idling, receiver holds off while queries pile up
        set_config(10'd16, 10'd16, 10'd7, 10'd16);
        calm     = 1;
        hold_req = 1;
        random_items(85);
        calm = 0;
        drain();

        if (sb.errors == 0 && sb.pending_votes.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/wmlv_pkg.sv
sv/wmlv_ram.sv
sv/wmlv_front.sv
sv/wmlv_back.sv
sv/window_mode_label_vote.sv
bench/window_mode_label_vote_tb.sv
